// ===== hdl/casg_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Circular arc step generator package
// Shared widths, register indexes, step tables and interface structs.
// ----------------------------------------------------------------------------
package casg_pkg;

    localparam int CASG_COORD_WIDTH = 16;
    localparam int RADIUS_W         = 15;
    localparam int R2_W             = 2 * RADIUS_W;
    localparam int CFG_INDEX_W      = 8;
    localparam int CFG_DATA_W       = 16;
    localparam int M_TDATA_W        = 8;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_RADIUS    = 8'd0,
        CFG_DIRECTION = 8'd1
    } cfg_index_t;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    typedef struct packed {
        logic [RADIUS_W-1:0] radius;
        logic                direction;
        logic [R2_W-1:0]     r2;
    } cfg_t;

    typedef struct packed {
        logic signed [1:0] step_x;
        logic signed [1:0] step_y;
        logic              arc_done;
    } result_t;

    // Index: direction, f >= 0, x >= 0, y >= 0 from the highest bit down.
    localparam logic signed [1:0] STEP_X_TAB [16] = '{
        2'sd0, -2'sd1, 2'sd1, 2'sd0, 2'sd1, 2'sd0, 2'sd0, -2'sd1,
        -2'sd1, 2'sd0, 2'sd0, 2'sd1, 2'sd0, 2'sd1, -2'sd1, 2'sd0
    };
    localparam logic signed [1:0] STEP_Y_TAB [16] = '{
        -2'sd1, 2'sd0, 2'sd0, 2'sd1, 2'sd0, -2'sd1, 2'sd1, 2'sd0,
        2'sd0, 2'sd1, -2'sd1, 2'sd0, 2'sd1, 2'sd0, 2'sd0, -2'sd1
    };

endpackage

// ===== hdl/casg_cfg_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Configuration registers
// Holds radius and direction, and keeps the squared radius ready for the core.
// ----------------------------------------------------------------------------
module casg_cfg_regs
    import casg_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output cfg_t                   cfg
);

    logic [RADIUS_W-1:0] radius_reg, radius_next;
    logic                direction_reg, direction_next;
    logic [R2_W-1:0]     r2_reg, r2_next;
    logic [RADIUS_W-1:0] wr_radius;

    assign cfg_ready = 1'b1;
    assign wr_radius = cfg_data[RADIUS_W-1:0];

    always_comb begin
        radius_next    = radius_reg;
        direction_next = direction_reg;
        r2_next        = r2_reg;
        if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_RADIUS: begin
                    radius_next = wr_radius;
                    r2_next     = R2_W'(wr_radius) * R2_W'(wr_radius);
                end
                CFG_DIRECTION: begin
                    direction_next = cfg_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg    <= '0;
            direction_reg <= 1'b0;
            r2_reg        <= '0;
        end else begin
            radius_reg    <= radius_next;
            direction_reg <= direction_next;
            r2_reg        <= r2_next;
        end
    end

    assign cfg.radius    = radius_reg;
    assign cfg.direction = direction_reg;
    assign cfg.r2        = r2_reg;

endmodule

// ===== hdl/casg_arc_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Arc stepping core
// Holds position, start point and activity, and forms one step per transaction.
// ----------------------------------------------------------------------------
module casg_arc_core
    import casg_pkg::*;
#(
    parameter int COORD_WIDTH = CASG_COORD_WIDTH
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          advance,
    input  logic                          mode,
    input  logic signed [COORD_WIDTH-1:0] start_x,
    input  logic signed [COORD_WIDTH-1:0] start_y,
    input  cfg_t                          cfg,
    output result_t                       result
);

    localparam int POS_W = COORD_WIDTH + 1;
    localparam int SQ_W  = 2 * POS_W;
    localparam int CMP_W = (SQ_W > R2_W) ? SQ_W + 1 : R2_W + 1;

    logic signed [POS_W-1:0]       pos_x_reg, pos_x_next;
    logic signed [POS_W-1:0]       pos_y_reg, pos_y_next;
    logic signed [COORD_WIDTH-1:0] origin_x_reg, origin_x_next;
    logic signed [COORD_WIDTH-1:0] origin_y_reg, origin_y_next;
    logic                          active_reg, active_next;

    logic signed [SQ_W-1:0]  px_ext, py_ext, sq_x, sq_y;
    logic [CMP_W-1:0]        sum_sq;
    logic                    outside;
    logic [3:0]              tab_idx;
    logic signed [1:0]       tab_x, tab_y;
    logic signed [POS_W-1:0] moved_x, moved_y;
    logic                    radius_zero;
    logic                    back_at_start;

    assign px_ext  = SQ_W'(pos_x_reg);
    assign py_ext  = SQ_W'(pos_y_reg);
    assign sq_x    = px_ext * px_ext;
    assign sq_y    = py_ext * py_ext;
    assign sum_sq  = CMP_W'($unsigned(sq_x)) + CMP_W'($unsigned(sq_y));
    assign outside = (sum_sq >= CMP_W'(cfg.r2));

    assign tab_idx = {cfg.direction, outside, !pos_x_reg[POS_W-1], !pos_y_reg[POS_W-1]};
    assign tab_x   = STEP_X_TAB[tab_idx];
    assign tab_y   = STEP_Y_TAB[tab_idx];

    assign moved_x = pos_x_reg + POS_W'(tab_x);
    assign moved_y = pos_y_reg + POS_W'(tab_y);

    assign radius_zero   = (cfg.radius == '0);
    assign back_at_start = (moved_x == POS_W'(origin_x_reg))
                        && (moved_y == POS_W'(origin_y_reg));

    always_comb begin
        pos_x_next      = pos_x_reg;
        pos_y_next      = pos_y_reg;
        origin_x_next   = origin_x_reg;
        origin_y_next   = origin_y_reg;
        active_next     = active_reg;
        result.step_x   = 2'sd0;
        result.step_y   = 2'sd0;
        result.arc_done = 1'b1;
        if (mode == MODE_LOAD) begin
            origin_x_next   = start_x;
            origin_y_next   = start_y;
            pos_x_next      = POS_W'(start_x);
            pos_y_next      = POS_W'(start_y);
            active_next     = 1'b1;
            result.arc_done = radius_zero;
        end else if (active_reg && !radius_zero) begin
            pos_x_next      = moved_x;
            pos_y_next      = moved_y;
            active_next     = !back_at_start;
            result.step_x   = tab_x;
            result.step_y   = tab_y;
            result.arc_done = back_at_start;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_x_reg    <= '0;
            pos_y_reg    <= '0;
            origin_x_reg <= '0;
            origin_y_reg <= '0;
            active_reg   <= 1'b0;
        end else if (advance) begin
            pos_x_reg    <= pos_x_next;
            pos_y_reg    <= pos_y_next;
            origin_x_reg <= origin_x_next;
            origin_y_reg <= origin_y_next;
            active_reg   <= active_next;
        end
    end

    a_idle_no_step: assert property (@(posedge aclk) disable iff (!aresetn)
        !active_reg |-> (result.step_x == 2'sd0 && result.step_y == 2'sd0))
        else $error("step issued while no arc is active");

    a_one_axis: assert property (@(posedge aclk) disable iff (!aresetn)
        (mode == MODE_TICK && active_reg && !radius_zero)
        |-> ((result.step_x != 2'sd0) != (result.step_y != 2'sd0)))
        else $error("active tick must move exactly one axis");

    a_done_stops: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && mode == MODE_TICK && result.arc_done && !radius_zero) |=> !active_reg)
        else $error("arc still active after completion");

    a_load_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && mode == MODE_LOAD) |=> active_reg)
        else $error("load did not start an arc");

endmodule

// ===== hdl/circular_arc_step_generator_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Circular arc step generator
// m_tvalid rises once the input register's transaction advances into the result register, when that one is free.
// One transaction per cycle while m_tready does not stall; the position registers update as a transaction advances.
// A stall on m_tready holds both registers and drops s_tready once the input register is full.
// Reset: synchronous, active low; clears position, start point, activity, configuration and valids, not data registers.
// ----------------------------------------------------------------------------
module circular_arc_step_generator_top
    import casg_pkg::*;
#(
    parameter int COORD_WIDTH = CASG_COORD_WIDTH
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // start_x, start_y
    input  logic [((2*COORD_WIDTH+7)/8)*8-1:0]    s_tdata,
    // mode
    input  logic                                  s_tuser,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // step_x, step_y, arc_done
    output logic [M_TDATA_W-1:0]                  m_tdata,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [CFG_INDEX_W-1:0]                cfg_index,
    input  logic [CFG_DATA_W-1:0]                 cfg_data
);

    cfg_t    cfg;
    result_t core_result;

    logic                          in_valid_reg;
    logic                          mode_reg;
    logic signed [COORD_WIDTH-1:0] start_x_reg, start_y_reg;
    logic                          out_valid_reg;
    result_t                       out_reg;
    logic                          advance;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            mode_reg    <= s_tuser;
            start_x_reg <= s_tdata[COORD_WIDTH-1:0];
            start_y_reg <= s_tdata[2*COORD_WIDTH-1:COORD_WIDTH];
        end
    end

    casg_cfg_regs u_cfg_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    casg_arc_core #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_arc_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .mode    (mode_reg),
        .start_x (start_x_reg),
        .start_y (start_y_reg),
        .cfg     (cfg),
        .result  (core_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= core_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(M_TDATA_W - 5)'(0), out_reg.arc_done, out_reg.step_y, out_reg.step_x};

endmodule
